### rtl/srme_pkg.sv
// Package: shared types and codes for the sorted range map engine
package srme_pkg;

    // Request actions
    localparam logic [1:0] ACT_ALLOC  = 2'd0;
    localparam logic [1:0] ACT_FREE   = 2'd1;
    localparam logic [1:0] ACT_LOOKUP = 2'd2;
    localparam logic [1:0] ACT_OVLP   = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_INV  = 2'd1;
    localparam logic [1:0] ST_BUSY = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    // Register indexes
    localparam logic REG_LOW  = 1'b0;
    localparam logic REG_HIGH = 1'b1;

    // Table operation sent to every cell
    typedef enum logic [2:0] {
        OP_NONE,
        OP_INSERT,
        OP_REMOVE,
        OP_SET_START,
        OP_SET_END,
        OP_SPLIT
    } t_op;

endpackage

### rtl/srme_if.sv
// Interface: valid/ready channel carrying one payload
interface srme_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/srme_cell.sv
// Module: one slot of the sorted range table with its compares and shift logic
module srme_cell #(
    parameter int ADDR_BITS = 32,
    parameter int TAG_BITS  = 16,
    parameter int IDX_BITS  = 6
) (
    input  logic                 i_clk,
    input  logic [IDX_BITS-1:0]  i_idx,
    // neighbour entries
    input  logic [ADDR_BITS-1:0] i_prev_start,
    input  logic [ADDR_BITS-1:0] i_prev_end,
    input  logic [TAG_BITS-1:0]  i_prev_tag,
    input  logic [ADDR_BITS-1:0] i_next_start,
    input  logic [ADDR_BITS-1:0] i_next_end,
    input  logic [TAG_BITS-1:0]  i_next_tag,
    // broadcast update
    input  srme_pkg::t_op        i_op,
    input  logic [IDX_BITS-1:0]  i_pos,
    input  logic [ADDR_BITS-1:0] i_start,
    input  logic [ADDR_BITS-1:0] i_end,
    input  logic [TAG_BITS-1:0]  i_tag,
    // search key
    input  logic [ADDR_BITS-1:0] i_key,
    output logic                 o_below,
    output logic [ADDR_BITS-1:0] o_start,
    output logic [ADDR_BITS-1:0] o_end,
    output logic [TAG_BITS-1:0]  o_tag
);
    logic [ADDR_BITS-1:0] r_start, n_start;
    logic [ADDR_BITS-1:0] r_end, n_end;
    logic [TAG_BITS-1:0]  r_tag, n_tag;

    assign o_start = r_start;
    assign o_end   = r_end;
    assign o_tag   = r_tag;
    // entry ends before the key
    assign o_below = r_end < i_key;

    // next entry contents for the broadcast operation
    always_comb begin
        n_start = r_start;
        n_end   = r_end;
        n_tag   = r_tag;
        case (i_op)
            srme_pkg::OP_INSERT: begin
                if (i_idx == i_pos) begin
                    n_start = i_start; n_end = i_end; n_tag = i_tag;
                end else if (i_idx > i_pos) begin
                    n_start = i_prev_start; n_end = i_prev_end; n_tag = i_prev_tag;
                end
            end
            srme_pkg::OP_REMOVE: begin
                if (i_idx >= i_pos) begin
                    n_start = i_next_start; n_end = i_next_end; n_tag = i_next_tag;
                end
            end
            srme_pkg::OP_SET_START: begin
                if (i_idx == i_pos) n_start = i_start;
            end
            srme_pkg::OP_SET_END: begin
                if (i_idx == i_pos) n_end = i_end;
            end
            srme_pkg::OP_SPLIT: begin
                // i_pos is the entry being split; new upper part goes after it
                if (i_idx == i_pos) begin
                    n_end = i_end;
                end else if (i_idx == i_pos + 1'b1) begin
                    n_start = i_start; n_end = i_prev_end; n_tag = i_prev_tag;
                end else if (i_idx > i_pos) begin
                    n_start = i_prev_start; n_end = i_prev_end; n_tag = i_prev_tag;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_start <= n_start;
        r_end   <= n_end;
        r_tag   <= n_tag;
    end
endmodule

### rtl/srme_chain.sv
// Module: row of table cells with registered first-not-below search
module srme_chain #(
    parameter int MAX_RANGES = 64,
    parameter int ADDR_BITS  = 32,
    parameter int TAG_BITS   = 16,
    parameter int IDX_BITS   = 6
) (
    input  logic                 i_clk,
    input  srme_pkg::t_op        i_op,
    input  logic [IDX_BITS-1:0]  i_pos,
    input  logic [ADDR_BITS-1:0] i_start,
    input  logic [ADDR_BITS-1:0] i_end,
    input  logic [TAG_BITS-1:0]  i_tag,
    input  logic [ADDR_BITS-1:0] i_key,
    input  logic [IDX_BITS:0]    i_used,
    input  logic [IDX_BITS:0]    i_sel,
    // registered first-not-below index
    output logic [IDX_BITS:0]    o_first,
    // entries at i_sel and i_sel-1, registered
    output logic [ADDR_BITS-1:0] o_cur_start,
    output logic [ADDR_BITS-1:0] o_cur_end,
    output logic [TAG_BITS-1:0]  o_cur_tag,
    output logic [ADDR_BITS-1:0] o_prv_end,
    output logic [TAG_BITS-1:0]  o_prv_tag
);
    logic [ADDR_BITS-1:0] w_s [MAX_RANGES];
    logic [ADDR_BITS-1:0] w_e [MAX_RANGES];
    logic [TAG_BITS-1:0]  w_t [MAX_RANGES];
    logic [MAX_RANGES-1:0] w_below;
    logic [IDX_BITS:0]     n_first;
    logic [IDX_BITS-1:0]   w_ci, w_pi;

    for (genvar g = 0; g < MAX_RANGES; g++) begin : g_cell
        localparam int P = (g == 0) ? 0 : g - 1;
        localparam int N = (g == MAX_RANGES - 1) ? g : g + 1;
        logic w_b;
        srme_cell #(
            .ADDR_BITS(ADDR_BITS), .TAG_BITS(TAG_BITS), .IDX_BITS(IDX_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_idx        (IDX_BITS'(g)),
            .i_prev_start (w_s[P]), .i_prev_end (w_e[P]), .i_prev_tag (w_t[P]),
            .i_next_start (w_s[N]), .i_next_end (w_e[N]), .i_next_tag (w_t[N]),
            .i_op         (i_op),
            .i_pos        (i_pos),
            .i_start      (i_start),
            .i_end        (i_end),
            .i_tag        (i_tag),
            .i_key        (i_key),
            .o_below      (w_b),
            .o_start      (w_s[g]),
            .o_end        (w_e[g]),
            .o_tag        (w_t[g])
        );
        // only live entries count as below
        assign w_below[g] = w_b && ((IDX_BITS+1)'(g) < i_used);
    end

    // table is sorted: the below flags form a prefix, so the first clear flag is the index
    always_comb begin
        n_first = (IDX_BITS+1)'(MAX_RANGES);
        for (int j = MAX_RANGES - 1; j >= 0; j--)
            if (!w_below[j]) n_first = (IDX_BITS+1)'(j);
    end

    assign w_ci = i_sel[IDX_BITS-1:0];
    assign w_pi = i_sel[IDX_BITS-1:0] - 1'b1;

    always_ff @(posedge i_clk) begin
        o_first     <= n_first;
        o_cur_start <= w_s[w_ci];
        o_cur_end   <= w_e[w_ci];
        o_cur_tag   <= w_t[w_ci];
        o_prv_end   <= w_e[w_pi];
        o_prv_tag   <= w_t[w_pi];
    end
endmodule

### rtl/sorted_range_map_engine.sv
// Top level: sorted range map engine
//
//  channel  dir  payload                                              handshake
//  i_req    in   action, addr, size, tag                              valid/ready
//  o_rsp    out  status, found, range_start, range_end, range_tag,   valid/ready
//               entry_count, sector_count
//  cfg      in   i_cfg_we, i_cfg_idx, i_cfg_data                      write only
//
// Each request passes through the capture cycle, a search pass over the cell
// row, a read of the matching entries, then the decision, whose row update
// lands at the same edge as the result beat. A merge with both neighbours ends
// with a removal in the following idle cycle, alongside the next capture.
// One request is in work at a time; a new one is taken once the result
// register is free or being drained, so a stalled result holds the input.
// Reset clears the entry count and the covered total and restores the bounds.
module sorted_range_map_engine #(
    parameter int MAX_RANGES = 64,
    parameter int ADDR_BITS  = 32,
    parameter int TAG_BITS   = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [ADDR_BITS-1:0] i_cfg_data,
    srme_if.sink                 i_req,
    srme_if.source               o_rsp
);
    localparam int IDX_BITS = $clog2(MAX_RANGES);

    typedef enum logic [1:0] { S_IDLE, S_SEARCH, S_READ, S_DECIDE } t_state;

    t_state               r_state;
    logic [1:0]           r_act;
    logic [ADDR_BITS-1:0] r_addr, r_size, r_end;
    logic [TAG_BITS-1:0]  r_tag;
    logic                 r_wf;
    logic [ADDR_BITS-1:0] r_low, r_high;
    logic [IDX_BITS:0]    r_used;
    logic [ADDR_BITS:0]   r_total;
    logic                 r_vld;
    logic [1:0]           r_st;
    logic                 r_fnd;
    logic [ADDR_BITS-1:0] r_rs, r_re;
    logic [TAG_BITS-1:0]  r_rt;
    logic                 r_merge2;
    logic [IDX_BITS-1:0]  r_mpos;

    srme_pkg::t_op        w_op;
    logic [IDX_BITS-1:0]  w_pos;
    srme_pkg::t_op        w_op_eff;
    logic [IDX_BITS-1:0]  w_pos_eff;
    logic [ADDR_BITS-1:0] w_ws, w_we;
    logic [TAG_BITS-1:0]  w_wt;
    logic [IDX_BITS:0]    w_first;
    logic [ADDR_BITS-1:0] w_cs, w_ce, w_pe;
    logic [TAG_BITS-1:0]  w_ct, w_pt;

    logic                 w_take;
    logic [ADDR_BITS-1:0] w_a, w_sz, w_sm1, w_e;
    logic                 w_wf;

    assign i_req.ready = (r_state == S_IDLE) && (!r_vld || o_rsp.ready);
    assign w_take      = i_req.valid && i_req.ready;
    assign w_a   = i_req.data.addr;
    assign w_sz  = i_req.data.size;
    assign w_sm1 = w_sz - 1'b1;
    assign w_wf  = (w_sz != '0) && (w_sm1 <= ~w_a);
    assign w_e   = w_a + w_sm1;

    srme_chain #(
        .MAX_RANGES(MAX_RANGES), .ADDR_BITS(ADDR_BITS),
        .TAG_BITS(TAG_BITS), .IDX_BITS(IDX_BITS)
    ) u_chain (
        .i_clk       (i_clk),
        .i_op        (w_op_eff),
        .i_pos       (w_pos_eff),
        .i_start     (w_ws),
        .i_end       (w_we),
        .i_tag       (w_wt),
        .i_key       (r_addr),
        .i_used      (r_used),
        .i_sel       (w_first),
        .o_first     (w_first),
        .o_cur_start (w_cs),
        .o_cur_end   (w_ce),
        .o_cur_tag   (w_ct),
        .o_prv_end   (w_pe),
        .o_prv_tag   (w_pt)
    );

    // decision over the registered entries
    logic                 d_hit, d_pvalid, d_inb, d_pm, d_nm;
    logic [1:0]           d_st;
    logic                 d_fnd;
    logic [ADDR_BITS-1:0] d_qe;

    always_comb begin
        w_op  = srme_pkg::OP_NONE;
        w_pos = w_first[IDX_BITS-1:0];
        w_ws  = r_addr;
        w_we  = r_end;
        w_wt  = r_tag;
        d_st  = srme_pkg::ST_OK;
        d_fnd = 1'b0;
        d_hit    = w_first < r_used;
        d_pvalid = w_first != '0;
        d_inb    = r_wf && r_addr >= r_low && r_end <= r_high;
        d_pm = (r_tag == '0) && d_pvalid && (w_pe + 1'b1 == r_addr) && (w_pt == '0)
               && (w_pe != '1);
        d_nm = (r_tag == '0) && d_hit && (r_end + 1'b1 == w_cs) && (w_ct == '0)
               && (r_end != '1);
        if (r_act == srme_pkg::ACT_OVLP)
            d_qe = (r_size == '0) ? '0 : (r_wf ? r_end : '1);
        else
            d_qe = r_addr;
        if (r_state == S_DECIDE) begin
            unique case (r_act)
                srme_pkg::ACT_ALLOC: begin
                    if (!d_inb || (d_hit && w_cs <= r_end)) begin
                        d_st = srme_pkg::ST_INV;
                    end else if (d_pm) begin
                        w_pos = w_pos - 1'b1;
                        if (d_nm) begin
                            // join both: extend previous, drop current
                            w_op = srme_pkg::OP_SPLIT;
                            w_we = w_ce;
                        end else begin
                            w_op = srme_pkg::OP_SET_END;
                        end
                    end else if (d_nm) begin
                        w_op = srme_pkg::OP_SET_START;
                    end else if (r_used >= (IDX_BITS+1)'(MAX_RANGES)) begin
                        d_st = srme_pkg::ST_FULL;
                    end else begin
                        w_op = srme_pkg::OP_INSERT;
                    end
                end
                srme_pkg::ACT_FREE: begin
                    if (!d_inb || !d_hit || w_cs > r_addr || r_end > w_ce) begin
                        d_st = srme_pkg::ST_INV;
                    end else if (w_ct != '0) begin
                        d_st = srme_pkg::ST_BUSY;
                    end else if (w_cs == r_addr) begin
                        if (w_ce == r_end) begin
                            w_op = srme_pkg::OP_REMOVE;
                        end else begin
                            w_op = srme_pkg::OP_SET_START;
                            w_ws = r_end + 1'b1;
                        end
                    end else if (w_ce == r_end) begin
                        w_op = srme_pkg::OP_SET_END;
                        w_we = r_addr - 1'b1;
                    end else if (r_used >= (IDX_BITS+1)'(MAX_RANGES)) begin
                        d_st = srme_pkg::ST_FULL;
                    end else begin
                        w_op = srme_pkg::OP_SPLIT;
                        w_we = r_addr - 1'b1;
                        w_ws = r_end + 1'b1;
                    end
                end
                srme_pkg::ACT_LOOKUP, srme_pkg::ACT_OVLP: begin
                    d_fnd = (r_act == srme_pkg::ACT_LOOKUP || r_size != '0)
                            && d_hit && w_cs <= d_qe;
                end
                default: ;
            endcase
        end
    end

    // a double merge is decoded as SPLIT at the previous slot; the row gets
    // SET_END there first, then a REMOVE of the current slot in the next cycle
    always_comb begin
        w_op_eff  = w_op;
        w_pos_eff = w_pos;
        if (r_merge2) begin
            w_op_eff  = srme_pkg::OP_REMOVE;
            w_pos_eff = r_mpos;
        end else if (r_state == S_DECIDE && r_act == srme_pkg::ACT_ALLOC
                     && w_op == srme_pkg::OP_SPLIT) begin
            w_op_eff = srme_pkg::OP_SET_END;
        end
    end

    // controller, bounds, counters and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_low    <= '0;
            r_high   <= '1;
            r_used   <= '0;
            r_total  <= '0;
            r_vld    <= 1'b0;
            r_merge2 <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == srme_pkg::REG_LOW) r_low  <= i_cfg_data;
                if (i_cfg_idx == srme_pkg::REG_HIGH) r_high <= i_cfg_data;
            end
            // result beat: loaded by the decision, freed by the sink
            if (r_state == S_DECIDE) r_vld <= 1'b1;
            else if (o_rsp.valid && o_rsp.ready) r_vld <= 1'b0;
            // removal still owed by a double merge
            r_merge2 <= (r_state == S_DECIDE) && (d_st == srme_pkg::ST_OK)
                        && (r_act == srme_pkg::ACT_ALLOC) && (w_op == srme_pkg::OP_SPLIT);
            unique case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        r_act   <= i_req.data.action;
                        r_addr  <= w_a;
                        r_size  <= w_sz;
                        r_tag   <= i_req.data.tag;
                        r_wf    <= w_wf;
                        r_end   <= w_wf ? w_e : w_a;
                        r_state <= S_SEARCH;
                    end
                end
                S_SEARCH: r_state <= S_READ;
                S_READ:   r_state <= S_DECIDE;
                S_DECIDE: begin
                    r_state <= S_IDLE;
                    r_st    <= d_st;
                    r_fnd   <= d_fnd;
                    r_rs    <= d_fnd ? w_cs : '0;
                    r_re    <= d_fnd ? w_ce : '0;
                    r_rt    <= d_fnd ? w_ct : '0;
                    if (d_st == srme_pkg::ST_OK) begin
                        if (r_act == srme_pkg::ACT_ALLOC) begin
                            r_total <= r_total + (ADDR_BITS+1)'(r_size);
                            if (w_op == srme_pkg::OP_INSERT) r_used <= r_used + 1'b1;
                            if (w_op == srme_pkg::OP_SPLIT) begin
                                r_used <= r_used - 1'b1;
                                r_mpos <= w_first[IDX_BITS-1:0];
                            end
                        end else if (r_act == srme_pkg::ACT_FREE) begin
                            r_total <= r_total - (ADDR_BITS+1)'(r_size);
                            if (w_op == srme_pkg::OP_SPLIT) r_used <= r_used + 1'b1;
                            if (w_op == srme_pkg::OP_REMOVE) r_used <= r_used - 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid             = r_vld;
    assign o_rsp.data.status       = r_st;
    assign o_rsp.data.found        = r_fnd;
    assign o_rsp.data.range_start  = r_rs;
    assign o_rsp.data.range_end    = r_re;
    assign o_rsp.data.range_tag    = r_rt;
    assign o_rsp.data.entry_count  = r_used;
    assign o_rsp.data.sector_count = r_total;
endmodule
